[hw/rtl/mte_pkg.sv]
// Package for the multiset table engine: request opcodes, field widths,
// controller/datapath command and status structs. No dependencies.
package mte_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int OP_W         = 2;
  localparam int VAL_W        = 32;
  localparam int CNT_W        = 7;
  localparam int IN_TDATA_W   = 72;
  localparam int OUT_TDATA_W  = 8;

  localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_REPLACE = 2'd2,
    OP_SEARCH  = 2'd3
  } mte_op_t;

  typedef struct packed {
    logic clear;
    logic start;
    logic scan;
    logic respond;
  } mte_cmd_t;

  typedef struct packed {
    logic addr_last;
    logic out_free;
  } mte_sts_t;

endpackage

[hw/rtl/mte_ctrl.sv]
// Controller for the multiset table engine: clearing pass, request accept,
// table scan sequencing and result hand-off. Depends on mte_pkg.
module mte_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  mte_pkg::mte_sts_t sts,
  output mte_pkg::mte_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_tready   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.addr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.addr_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.respond = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_SCAN))
    else $error("request accepted without starting a scan");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear, cmd.start, cmd.scan, cmd.respond}))
    else $error("more than one command issued");

  a_drain_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |=> (state_r == ST_RESP))
    else $error("drain not followed by response");

endmodule

[hw/rtl/mte_dpath.sv]
// Datapath for the multiset table engine: slot memory with valid bit,
// scan address, read-modify-write stage, hit count and result register.
// Depends on mte_pkg.
module mte_dpath #(
  parameter int CAPACITY = mte_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mte_pkg::mte_cmd_t               cmd,
  output mte_pkg::mte_sts_t               sts,
  input  logic [mte_pkg::OP_W-1:0]        req_operation,
  input  logic signed [mte_pkg::VAL_W-1:0] req_key,
  input  logic signed [mte_pkg::VAL_W-1:0] req_new_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_success,
  output logic [mte_pkg::CNT_W-1:0]       out_match_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > mte_pkg::CNT_W) ? CW : mte_pkg::CNT_W;
  localparam int WW = mte_pkg::VAL_W + 1;

  logic [WW-1:0]                  mem_r [CAPACITY];
  logic [AW-1:0]                  addr_r;
  logic [AW-1:0]                  addr_nxt;
  logic                           rd_pend_r;
  logic [AW-1:0]                  rd_idx_r;
  logic [WW-1:0]                  rd_word_r;
  mte_pkg::mte_op_t               op_r;
  logic signed [mte_pkg::VAL_W-1:0] key_r;
  logic signed [mte_pkg::VAL_W-1:0] newv_r;
  logic [CW-1:0]                  hits_r;
  logic                           placed_r;
  logic                           out_valid_r;
  logic                           out_success_r;
  logic [mte_pkg::CNT_W-1:0]      out_count_r;

  logic                           hit;
  logic                           free;
  logic                           wr_en;
  logic [AW-1:0]                  wr_idx;
  logic [WW-1:0]                  wr_word;
  logic                           hit_inc;
  logic                           place;
  logic [XW-1:0]                  hits_x;
  logic [mte_pkg::CNT_W-1:0]      count_sat;
  logic                           res_success;
  logic [mte_pkg::CNT_W-1:0]      res_count;

  assign sts.addr_last = (addr_r == AW'(CAPACITY - 1));
  assign sts.out_free  = !out_valid_r || out_ready;
  assign addr_nxt      = sts.addr_last ? '0 : addr_r + AW'(1);

  assign hit  = rd_pend_r && rd_word_r[WW-1] && (rd_word_r[WW-2:0] == key_r);
  assign free = rd_pend_r && !rd_word_r[WW-1];

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = rd_idx_r;
    wr_word = '0;
    hit_inc = 1'b0;
    place   = 1'b0;
    if (cmd.clear) begin
      wr_en  = 1'b1;
      wr_idx = addr_r;
    end else begin
      unique case (op_r)
        mte_pkg::OP_INSERT: begin
          if (free && !placed_r) begin
            wr_en   = 1'b1;
            wr_word = {1'b1, key_r};
            place   = 1'b1;
          end
        end
        mte_pkg::OP_REMOVE: begin
          if (hit) begin
            wr_en   = 1'b1;
            wr_word = {1'b0, rd_word_r[WW-2:0]};
            hit_inc = 1'b1;
          end
        end
        mte_pkg::OP_REPLACE: begin
          if (hit) begin
            wr_en   = 1'b1;
            wr_word = {1'b1, newv_r};
            hit_inc = 1'b1;
          end
        end
        mte_pkg::OP_SEARCH: begin
          hit_inc = hit;
        end
        default: begin
          hit_inc = 1'b0;
        end
      endcase
    end
  end

  assign hits_x    = XW'(hits_r);
  assign count_sat = (hits_x > XW'(mte_pkg::COUNT_MAX)) ? mte_pkg::COUNT_MAX
                                                        : hits_x[mte_pkg::CNT_W-1:0];

  always_comb begin
    res_success = (hits_r != '0);
    res_count   = '0;
    case (op_r)
      mte_pkg::OP_INSERT: begin
        res_success = placed_r;
      end
      mte_pkg::OP_REMOVE, mte_pkg::OP_REPLACE: begin
        res_count = count_sat;
      end
      default: begin
        res_count = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_idx] <= wr_word;
    rd_word_r <= mem_r[addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r   <= mte_pkg::mte_op_t'(req_operation);
      key_r  <= req_key;
      newv_r <= req_new_value;
    end
    if (cmd.scan) rd_idx_r <= addr_r;
    if (cmd.respond) begin
      out_success_r <= res_success;
      out_count_r   <= res_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      rd_pend_r   <= 1'b0;
      hits_r      <= '0;
      placed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.scan;
      if (cmd.start) begin
        addr_r   <= '0;
        hits_r   <= '0;
        placed_r <= 1'b0;
      end else begin
        if (cmd.clear || cmd.scan) addr_r <= addr_nxt;
        hits_r <= hits_r + CW'(hit_inc);
        if (place) placed_r <= 1'b1;
      end
      if (cmd.respond) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_success     = out_success_r;
  assign out_match_count = out_count_r;

  a_hits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hits_r <= CW'(CAPACITY))
    else $error("hit count beyond table size");

  a_place_insert_only: assert property (@(posedge clk) disable iff (!rst_n)
    placed_r |-> (op_r == mte_pkg::OP_INSERT))
    else $error("slot placed by a non-insert request");

  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !cmd.clear) |-> rd_pend_r)
    else $error("slot write without a pending read");

  a_respond_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.respond |=> out_valid_r)
    else $error("result not presented after respond");

endmodule

[hw/rtl/multiset_table_engine.sv]
// Multiset table engine: one request is accepted in the idle cycle, then the
// table is scanned one slot per cycle; the result is loaded into the output
// register after a drain state, and no new request is taken until it is loaded.
// The output register lets a result wait while the next request is accepted.
// Synchronous active-low reset starts a clearing pass over the slot memory;
// in_tready stays low until it ends.
module multiset_table_engine #(
  parameter int CAPACITY = mte_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [1:0] operation, [33:2] key, [65:34] new_value, [71:66] zero
  input  logic [mte_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] success, [7:1] match_count
  output logic [mte_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  mte_pkg::mte_cmd_t                 cmd;
  mte_pkg::mte_sts_t                 sts;
  logic                              res_success;
  logic [mte_pkg::CNT_W-1:0]         res_count;
  logic [mte_pkg::OP_W-1:0]          req_operation;
  logic signed [mte_pkg::VAL_W-1:0]  req_key;
  logic signed [mte_pkg::VAL_W-1:0]  req_new_value;

  assign req_operation = in_tdata[mte_pkg::OP_W-1:0];
  assign req_key       = in_tdata[mte_pkg::OP_W +: mte_pkg::VAL_W];
  assign req_new_value = in_tdata[mte_pkg::OP_W + mte_pkg::VAL_W +: mte_pkg::VAL_W];

  mte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mte_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .req_operation   (req_operation),
    .req_key         (req_key),
    .req_new_value   (req_new_value),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_success     (res_success),
    .out_match_count (res_count)
  );

  assign out_tdata = {res_count, res_success};

endmodule

[verif/multiset_table_checker.sv]
`timescale 1ns / 100ps
// Checker for the multiset table engine: watches the request and result streams,
// keeps its own slot table to predict each result and compares field by field.
// Depends on mte_pkg for opcodes and field widths.
module multiset_table_checker #(
  parameter int CAPACITY = mte_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [mte_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [mte_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            drain_done,
  output int                              fail_count,
  output int                              outstanding
);

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [mte_pkg::CNT_W-1:0] match_count;
    logic                      success;
  } response_t;

  typedef struct {
    response_t        resp;
    mte_pkg::mte_op_t op;
    logic [31:0]      key;
    int unsigned      serial;
  } awaited_t;

  logic [mte_pkg::VAL_W-1:0] table_value [CAPACITY];
  logic                      table_used  [CAPACITY];
  awaited_t                  awaited_q   [$];
  int unsigned               request_serial;
  bit                        drain_checked;

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic response_t apply_request(input mte_pkg::mte_op_t op,
                                              input logic [mte_pkg::VAL_W-1:0] key,
                                              input logic [mte_pkg::VAL_W-1:0] repl);
    response_t resp;
    int        hits;
    resp = '0;
    hits = 0;
    for (int i = 0; i < CAPACITY; i++) begin
      case (op)
        mte_pkg::OP_INSERT: begin
          if (!resp.success && !table_used[i]) begin
            table_used[i]  = 1'b1;
            table_value[i] = key;
            resp.success   = 1'b1;
          end
        end
        mte_pkg::OP_REMOVE: begin
          if (table_used[i] && table_value[i] == key) begin
            table_used[i] = 1'b0;
            hits++;
          end
        end
        mte_pkg::OP_REPLACE: begin
          if (table_used[i] && table_value[i] == key) begin
            table_value[i] = repl;
            hits++;
          end
        end
        default: begin
          if (table_used[i] && table_value[i] == key) resp.success = 1'b1;
        end
      endcase
    end
    if (op == mte_pkg::OP_REMOVE || op == mte_pkg::OP_REPLACE) begin
      resp.success     = (hits != 0);
      resp.match_count = (hits > mte_pkg::COUNT_MAX) ? mte_pkg::COUNT_MAX
                                                     : hits[mte_pkg::CNT_W-1:0];
    end
    return resp;
  endfunction

  always @(posedge clk) begin
    awaited_t         entry;
    mte_pkg::mte_op_t op;
    logic [31:0]      key;
    if (!rst_n) begin
      for (int i = 0; i < CAPACITY; i++) table_used[i] = 1'b0;
      awaited_q.delete();
      request_serial = 0;
      drain_checked  = 1'b0;
      fail_count     = 0;
      outstanding   <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        op           = mte_pkg::mte_op_t'(in_tdata[mte_pkg::OP_W-1:0]);
        key          = in_tdata[mte_pkg::OP_W +: mte_pkg::VAL_W];
        entry.op     = op;
        entry.key    = key;
        entry.serial = request_serial++;
        entry.resp   = apply_request(op, key,
                                     in_tdata[mte_pkg::OP_W+mte_pkg::VAL_W +: mte_pkg::VAL_W]);
        awaited_q.push_back(entry);
      end
      if (out_tvalid && out_tready) begin
        if (awaited_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no request outstanding", out_tdata));
        end else begin
          entry = awaited_q.pop_front();
          if (out_tdata[0] !== entry.resp.success)
            report_mismatch($sformatf("request %0d %s key %h: success %b, want %b",
                            entry.serial, entry.op.name(), entry.key, out_tdata[0],
                            entry.resp.success));
          if (out_tdata[mte_pkg::CNT_W:1] !== entry.resp.match_count)
            report_mismatch($sformatf("request %0d %s key %h: match_count %0d, want %0d",
                            entry.serial, entry.op.name(), entry.key,
                            out_tdata[mte_pkg::CNT_W:1], entry.resp.match_count));
        end
      end
      if (drain_done && !drain_checked) begin
        drain_checked = 1'b1;
        foreach (awaited_q[i])
          report_mismatch($sformatf("request %0d %s key %h never answered",
                          awaited_q[i].serial, awaited_q[i].op.name(), awaited_q[i].key));
      end
      outstanding <= awaited_q.size();
    end
  end

endmodule

[verif/tb_multiset_table_engine.sv]
`timescale 1ns / 100ps
// Testbench top for the multiset table engine: clock, reset, request stimulus
// and result backpressure; prediction and checking live in multiset_table_checker.
// Depends on mte_pkg, multiset_table_engine and multiset_table_checker.
module tb_multiset_table_engine;

  localparam int          CAPACITY     = mte_pkg::CAPACITY_DEF;
  localparam int          ITEM_TARGET  = 1800;
  localparam int          POOL_SIZE    = 8;
  localparam int          PAD_W        = mte_pkg::IN_TDATA_W - mte_pkg::OP_W
                                         - 2 * mte_pkg::VAL_W;
  localparam longint      LIMIT_CYCLES = 3_000_000;
  localparam logic [31:0] KEY_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] KEY_MIN      = 32'h8000_0000;
  localparam logic [31:0] KEY_ZERO     = 32'h0000_0000;
  localparam logic [31:0] KEY_NEG1     = 32'hFFFF_FFFF;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [mte_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [mte_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            drain_done = 1'b0;
  int                              fail_count;
  int                              outstanding;
  int                              receiver_stall_pct = 0;
  int                              sender_idle_pct    = 0;
  int                              stall_left         = 0;
  int                              sent               = 0;
  logic [31:0]                     key_pool [POOL_SIZE];

  multiset_table_engine #(.CAPACITY(CAPACITY)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  multiset_table_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .drain_done (drain_done),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("FAIL");
    $finish;
  end

  // hold off results: short random stalls plus an occasional long one
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (receiver_stall_pct != 0 && $urandom_range(199) == 0) begin
      stall_left <= $urandom_range(120, 20);
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  function automatic logic [31:0] fresh_key();
    case ($urandom_range(7))
      0:       return KEY_MAX;
      1:       return KEY_MIN;
      2:       return KEY_ZERO;
      3:       return KEY_NEG1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pool_key();
    return key_pool[$urandom_range(POOL_SIZE-1)];
  endfunction

  function automatic logic [31:0] pick_key();
    return ($urandom_range(9) == 0) ? $urandom : pool_key();
  endfunction

  task automatic send_request(input mte_pkg::mte_op_t op, input logic [31:0] key,
                              input logic [31:0] repl);
    int gap;
    gap = 0;
    if (sender_idle_pct != 0) begin
      if ($urandom_range(99) < 3) gap = $urandom_range(100, 1);
      while ($urandom_range(99) < sender_idle_pct) gap++;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{PAD_W{1'b0}}, repl, key, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic run_round(input int kind);
    int               n;
    mte_pkg::mte_op_t op;
    logic [31:0]      repl;
    case (kind)
      // insert between CAPACITY/2 and CAPACITY+6 keys so late inserts may hit a full store
      0: begin
        n = $urandom_range(CAPACITY + 6, CAPACITY / 2);
        repeat (n) send_request(mte_pkg::OP_INSERT, pool_key(), $urandom);
        repeat (3) send_request(mte_pkg::OP_SEARCH, pick_key(), $urandom);
      end
      1: begin
        n = $urandom_range(40, 10);
        repeat (n) begin
          op = mte_pkg::mte_op_t'($urandom_range(3));
          repl = ($urandom_range(4) == 0) ? $urandom : pool_key();
          send_request(op, (op == mte_pkg::OP_INSERT) ? pool_key() : pick_key(), repl);
        end
      end
      // drain all pool keys, then retire one key
      2: begin
        for (int i = 0; i < POOL_SIZE; i++)
          send_request(mte_pkg::OP_REMOVE, key_pool[i], $urandom);
        key_pool[$urandom_range(POOL_SIZE-1)] = fresh_key();
      end
      3: begin
        n = $urandom_range(20, 5);
        repeat (n) begin
          op = ($urandom_range(2) == 0) ? mte_pkg::OP_SEARCH : mte_pkg::OP_REPLACE;
          send_request(op, pool_key(), pool_key());
        end
      end
      default: begin
        n = $urandom_range(12, 3);
        repeat (n) send_request(mte_pkg::mte_op_t'($urandom_range(3, 1)), $urandom, $urandom);
      end
    endcase
  endtask

  initial begin
    int phase_end;
    foreach (key_pool[i]) key_pool[i] = fresh_key();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_request(mte_pkg::OP_SEARCH,  KEY_MAX,       KEY_MIN);
    send_request(mte_pkg::OP_REMOVE,  KEY_MIN,       KEY_MAX);
    send_request(mte_pkg::OP_REPLACE, KEY_ZERO,      KEY_NEG1);
    send_request(mte_pkg::OP_INSERT,  KEY_MAX,       KEY_ZERO);
    send_request(mte_pkg::OP_INSERT,  KEY_MIN,       KEY_MAX);
    send_request(mte_pkg::OP_INSERT,  KEY_ZERO,      KEY_NEG1);
    send_request(mte_pkg::OP_INSERT,  KEY_NEG1,      KEY_MIN);
    send_request(mte_pkg::OP_INSERT,  KEY_MAX,       KEY_ZERO);
    send_request(mte_pkg::OP_SEARCH,  KEY_MAX,       KEY_ZERO);
    send_request(mte_pkg::OP_SEARCH,  KEY_MIN,       KEY_ZERO);
    send_request(mte_pkg::OP_SEARCH,  32'h1,         KEY_ZERO);
    send_request(mte_pkg::OP_REPLACE, KEY_MAX,       KEY_MAX);
    send_request(mte_pkg::OP_REPLACE, KEY_MAX,       KEY_MIN);
    send_request(mte_pkg::OP_REMOVE,  KEY_MIN,       KEY_ZERO);
    send_request(mte_pkg::OP_SEARCH,  KEY_MIN,       KEY_ZERO);
    send_request(mte_pkg::OP_REPLACE, KEY_NEG1,      KEY_ZERO);
    send_request(mte_pkg::OP_REMOVE,  KEY_ZERO,      KEY_ZERO);
    send_request(mte_pkg::OP_INSERT,  32'h5555_5555, 32'hAAAA_AAAA);
    send_request(mte_pkg::OP_SEARCH,  32'h5555_5555, 32'hAAAA_AAAA);
    send_request(mte_pkg::OP_REMOVE,  32'h5555_5555, 32'hAAAA_AAAA);
    send_request(mte_pkg::OP_REMOVE,  32'h5555_5555, 32'hAAAA_AAAA);
    pause_until_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin sender_idle_pct = 0;  receiver_stall_pct <= 0;  end
        1:       begin sender_idle_pct = 59; receiver_stall_pct <= 0;  end
        2:       begin sender_idle_pct = 0;  receiver_stall_pct <= 59; end
        default: begin sender_idle_pct = 33; receiver_stall_pct <= 33; end
      endcase
      phase_end = (phase + 1) * ITEM_TARGET / 4;
      run_round(0);
      while (sent < phase_end) run_round($urandom_range(4));
      pause_until_drained();
    end

    repeat (CAPACITY + 10) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
